// File: sv/array_linked_list_free_list_defines.svh
// Assertion macros shared by the linked list free list RTL.
`ifndef ARRAY_LINKED_LIST_FREE_LIST_DEFINES_SVH
`define ARRAY_LINKED_LIST_FREE_LIST_DEFINES_SVH

// Checked on every rising clock edge, off while reset is held.
`define ALLFL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ALLFL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: sv/allfl_pkg.sv
// Package: sizes, codes, types and helpers of the linked list free list block.
package allfl_pkg;

    // Store geometry
    localparam int SLOTS     = 64;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int LINK_BITS = SLOT_BITS + 1;
    localparam int KEY_BITS  = 32;
    localparam int STEP_BITS = $clog2(4 * SLOTS + 1);

    // Port field widths
    localparam int MODE_BITS   = 2;
    localparam int STATUS_BITS = 2;
    localparam int FIELD_BITS  = 7;
    localparam int OUT_BITS    = STATUS_BITS + 3 * FIELD_BITS;
    localparam int OUT_PAD     = ((OUT_BITS + 7) / 8) * 8 - OUT_BITS;
    localparam int OUT_WORD    = OUT_BITS + OUT_PAD;

    typedef logic [LINK_BITS-1:0] t_link;
    typedef logic [SLOT_BITS-1:0] t_slot;
    typedef logic [KEY_BITS-1:0]  t_key;
    typedef logic [STEP_BITS-1:0] t_step;

    localparam t_link NONE_LINK    = t_link'(SLOTS);
    localparam t_link SLOTS_LINK   = t_link'(SLOTS);
    localparam t_step CP_STEP_MAX  = t_step'(4 * SLOTS);
    localparam t_slot LAST_SLOT    = t_slot'(SLOTS - 1);

    typedef enum logic [MODE_BITS-1:0] {
        MODE_APPEND  = 2'd0,
        MODE_DELETE  = 2'd1,
        MODE_COMPACT = 2'd2,
        MODE_NOP     = 2'd3
    } t_mode;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_AP_W0,
        ST_AP_W1,
        ST_DL_WALK,
        ST_DL_U0,
        ST_DL_U1,
        ST_DL_U2,
        ST_CP_CHECK,
        ST_CP_ADV_L,
        ST_CP_ADV_F,
        ST_CP_RD_F,
        ST_CP_CAP_F,
        ST_CP_W0,
        ST_CP_W1,
        ST_CP_W2,
        ST_CP_W3,
        ST_FINISH
    } t_state;

    // One write port of a link memory
    typedef struct packed {
        logic  we;
        t_slot addr;
        t_link data;
    } t_link_wr;

    function automatic logic is_slot(input t_link x);
        return x < SLOTS_LINK;
    endfunction

    // Out-of-range links read as none
    function automatic t_link norm_link(input t_link x);
        return is_slot(x) ? x : NONE_LINK;
    endfunction

    function automatic t_slot slot_of(input t_link x);
        return x[SLOT_BITS-1:0];
    endfunction

endpackage

// File: sv/array_linked_list_free_list.sv
// Top level: doubly linked key list with free list, kept in next, prev and key memories.
//
//  Channel | Dir | Signals                          | Word
//  --------+-----+----------------------------------+------------------------------------
//  s       | in  | i_s_tvalid o_s_tready tdata tuser| tdata key_value, tuser mode
//  m       | out | o_m_tvalid i_m_tready tdata      | status, length, head_slot, tail_slot
//
//  One operation at a time; memory read data is registered.
//  Append fills a free slot, then links it. Delete compares list entries in turn, then unlinks.
//  Compactify: walk steps and swaps, at most 4*SLOTS steps in all.
//  Full store, empty list and unused mode go straight to the finish state.
//  After reset a pass over all SLOTS slots sets the link memories; no word is taken meanwhile.
//  A finished result waits in the output register; the next word is taken behind it.
`include "array_linked_list_free_list_defines.svh"

module array_linked_list_free_list (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic signed [31:0]                i_s_tdata,  // [31:0] key_value
    input  logic [allfl_pkg::MODE_BITS-1:0]   i_s_tuser,  // [1:0] mode
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [1:0] status, [8:2] length, [15:9] head_slot, [22:16] tail_slot, [23] zero
    output logic [allfl_pkg::OUT_WORD-1:0]    o_m_tdata
);

    // Memories and their read data
    allfl_pkg::t_link mem_next [allfl_pkg::SLOTS];
    allfl_pkg::t_link mem_prev [allfl_pkg::SLOTS];
    allfl_pkg::t_key  mem_key  [allfl_pkg::SLOTS];
    allfl_pkg::t_link r_next_q, r_prev_q;
    allfl_pkg::t_key  r_key_q;

    // Memory port controls
    allfl_pkg::t_link_wr next_wr, prev_wr;
    logic                key_we;
    allfl_pkg::t_slot    key_wa;
    allfl_pkg::t_key     key_wd;
    logic                rd_en;
    allfl_pkg::t_slot    rd_addr;

    // Control state
    allfl_pkg::t_state r_state, n_state;
    allfl_pkg::t_slot  r_init_idx, n_init_idx;
    allfl_pkg::t_link  r_free_head, n_free_head;
    allfl_pkg::t_link  r_head, n_head;
    allfl_pkg::t_link  r_tail, n_tail;
    allfl_pkg::t_link  r_len, n_len;
    logic              r_out_valid, n_out_valid;

    // Working registers
    allfl_pkg::t_key    r_key, n_key;
    allfl_pkg::t_link   r_slot, n_slot;
    allfl_pkg::t_link   r_nf, n_nf;
    allfl_pkg::t_link   r_li, n_li;
    allfl_pkg::t_link   r_fi, n_fi;
    allfl_pkg::t_link   r_ln, n_ln;
    allfl_pkg::t_link   r_lp, n_lp;
    allfl_pkg::t_link   r_fn, n_fn;
    allfl_pkg::t_link   r_fp, n_fp;
    allfl_pkg::t_key    r_swap_key, n_swap_key;
    allfl_pkg::t_link   r_dsteps, n_dsteps;
    allfl_pkg::t_step   r_csteps, n_csteps;
    allfl_pkg::t_status r_status, n_status;

    // Output word
    allfl_pkg::t_status                   r_out_status, n_out_status;
    logic [allfl_pkg::FIELD_BITS-1:0]     r_out_len, n_out_len;
    logic [allfl_pkg::FIELD_BITS-1:0]     r_out_head, n_out_head;
    logic [allfl_pkg::FIELD_BITS-1:0]     r_out_tail, n_out_tail;

    logic             s_acc;
    allfl_pkg::t_link step_n;

    // Flags used by the checks
    logic             no_head, no_tail, len_zero;

    assign o_s_tready = (r_state == allfl_pkg::ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{allfl_pkg::OUT_PAD{1'b0}}, r_out_tail, r_out_head, r_out_len,
                         r_out_status};
    assign step_n     = r_dsteps + allfl_pkg::t_link'(1);
    assign no_head    = (r_head == allfl_pkg::NONE_LINK);
    assign no_tail    = (r_tail == allfl_pkg::NONE_LINK);
    assign len_zero   = (r_len == '0);

    // Memory ports: one write each, one shared read address, read data registered
    always_ff @(posedge i_clk) begin
        if (next_wr.we) begin
            mem_next[next_wr.addr] <= next_wr.data;
        end
        if (prev_wr.we) begin
            mem_prev[prev_wr.addr] <= prev_wr.data;
        end
        if (key_we) begin
            mem_key[key_wa] <= key_wd;
        end
        if (rd_en) begin
            r_next_q <= mem_next[rd_addr];
            r_prev_q <= mem_prev[rd_addr];
            r_key_q  <= mem_key[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= allfl_pkg::ST_INIT;
            r_init_idx  <= '0;
            r_free_head <= '0;
            r_head      <= allfl_pkg::NONE_LINK;
            r_tail      <= allfl_pkg::NONE_LINK;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_idx  <= n_init_idx;
            r_free_head <= n_free_head;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_slot       <= n_slot;
        r_nf         <= n_nf;
        r_li         <= n_li;
        r_fi         <= n_fi;
        r_ln         <= n_ln;
        r_lp         <= n_lp;
        r_fn         <= n_fn;
        r_fp         <= n_fp;
        r_swap_key   <= n_swap_key;
        r_dsteps     <= n_dsteps;
        r_csteps     <= n_csteps;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_len    <= n_out_len;
        r_out_head   <= n_out_head;
        r_out_tail   <= n_out_tail;
    end

    // Sequencer: next state, memory accesses, list registers
    always_comb begin
        n_state      = r_state;
        n_init_idx   = r_init_idx;
        n_free_head  = r_free_head;
        n_head       = r_head;
        n_tail       = r_tail;
        n_len        = r_len;
        n_out_valid  = r_out_valid;
        n_key        = r_key;
        n_slot       = r_slot;
        n_nf         = r_nf;
        n_li         = r_li;
        n_fi         = r_fi;
        n_ln         = r_ln;
        n_lp         = r_lp;
        n_fn         = r_fn;
        n_fp         = r_fp;
        n_swap_key   = r_swap_key;
        n_dsteps     = r_dsteps;
        n_csteps     = r_csteps;
        n_status     = r_status;
        n_out_status = r_out_status;
        n_out_len    = r_out_len;
        n_out_head   = r_out_head;
        n_out_tail   = r_out_tail;
        next_wr      = '0;
        prev_wr      = '0;
        key_we       = 1'b0;
        key_wa       = allfl_pkg::slot_of(r_fi);
        key_wd       = r_swap_key;
        rd_en        = 1'b0;
        rd_addr      = '0;

        // result taken downstream
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            // clearing pass: slot i links to i+1 and i-1
            allfl_pkg::ST_INIT: begin
                next_wr.we   = 1'b1;
                next_wr.addr = r_init_idx;
                next_wr.data = (r_init_idx == allfl_pkg::LAST_SLOT) ? allfl_pkg::NONE_LINK
                             : allfl_pkg::t_link'(r_init_idx) + allfl_pkg::t_link'(1);
                prev_wr.we   = 1'b1;
                prev_wr.addr = r_init_idx;
                prev_wr.data = (r_init_idx == '0) ? allfl_pkg::NONE_LINK
                             : allfl_pkg::t_link'(r_init_idx) - allfl_pkg::t_link'(1);
                n_init_idx   = r_init_idx + allfl_pkg::t_slot'(1);
                if (r_init_idx == allfl_pkg::LAST_SLOT) begin
                    n_state = allfl_pkg::ST_IDLE;
                end
            end

            allfl_pkg::ST_IDLE: begin
                if (s_acc) begin
                    n_key    = allfl_pkg::t_key'(i_s_tdata);
                    n_status = allfl_pkg::STAT_OK;
                    case (allfl_pkg::t_mode'(i_s_tuser))
                        allfl_pkg::MODE_APPEND: begin
                            if (!allfl_pkg::is_slot(r_free_head)) begin
                                n_status = allfl_pkg::STAT_FULL;
                                n_state  = allfl_pkg::ST_FINISH;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = allfl_pkg::slot_of(r_free_head);
                                n_slot  = r_free_head;
                                n_state = allfl_pkg::ST_AP_W0;
                            end
                        end
                        allfl_pkg::MODE_DELETE: begin
                            if (!allfl_pkg::is_slot(r_head)) begin
                                n_status = allfl_pkg::STAT_EMPTY;
                                n_state  = allfl_pkg::ST_FINISH;
                            end else begin
                                rd_en    = 1'b1;
                                rd_addr  = allfl_pkg::slot_of(r_head);
                                n_slot   = r_head;
                                n_dsteps = '0;
                                n_state  = allfl_pkg::ST_DL_WALK;
                            end
                        end
                        allfl_pkg::MODE_COMPACT: begin
                            n_li     = r_head;
                            n_fi     = r_free_head;
                            n_csteps = '0;
                            n_state  = allfl_pkg::ST_CP_CHECK;
                        end
                        default: begin
                            n_state = allfl_pkg::ST_FINISH;
                        end
                    endcase
                end
            end

            // append: fill the free slot, then link it behind the tail
            allfl_pkg::ST_AP_W0: begin
                n_nf         = r_next_q;
                key_we       = 1'b1;
                key_wa       = allfl_pkg::slot_of(r_slot);
                key_wd       = r_key;
                next_wr.we   = 1'b1;
                next_wr.addr = allfl_pkg::slot_of(r_slot);
                next_wr.data = allfl_pkg::NONE_LINK;
                prev_wr.we   = 1'b1;
                prev_wr.addr = allfl_pkg::slot_of(r_slot);
                prev_wr.data = r_tail;
                n_state      = allfl_pkg::ST_AP_W1;
            end

            allfl_pkg::ST_AP_W1: begin
                next_wr.we   = allfl_pkg::is_slot(r_tail);
                next_wr.addr = allfl_pkg::slot_of(r_tail);
                next_wr.data = r_slot;
                prev_wr.we   = allfl_pkg::is_slot(r_nf);
                prev_wr.addr = allfl_pkg::slot_of(r_nf);
                prev_wr.data = allfl_pkg::NONE_LINK;
                if (!allfl_pkg::is_slot(r_tail)) begin
                    n_head = r_slot;
                end
                n_tail      = r_slot;
                n_free_head = allfl_pkg::norm_link(r_nf);
                n_len       = r_len + allfl_pkg::t_link'(1);
                n_state     = allfl_pkg::ST_FINISH;
            end

            // delete: one list entry compared per cycle
            allfl_pkg::ST_DL_WALK: begin
                if (r_key_q == r_key) begin
                    n_ln    = r_next_q;
                    n_lp    = r_prev_q;
                    n_state = allfl_pkg::ST_DL_U0;
                end else if (!allfl_pkg::is_slot(r_next_q) ||
                             step_n >= allfl_pkg::SLOTS_LINK) begin
                    n_status = allfl_pkg::STAT_NOT_FOUND;
                    n_state  = allfl_pkg::ST_FINISH;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = allfl_pkg::slot_of(r_next_q);
                    n_slot   = r_next_q;
                    n_dsteps = step_n;
                end
            end

            // unlink from neighbors
            allfl_pkg::ST_DL_U0: begin
                next_wr.we   = allfl_pkg::is_slot(r_lp);
                next_wr.addr = allfl_pkg::slot_of(r_lp);
                next_wr.data = allfl_pkg::norm_link(r_ln);
                prev_wr.we   = allfl_pkg::is_slot(r_ln);
                prev_wr.addr = allfl_pkg::slot_of(r_ln);
                prev_wr.data = allfl_pkg::norm_link(r_lp);
                n_state      = allfl_pkg::ST_DL_U1;
            end

            // freed slot heads the free list
            allfl_pkg::ST_DL_U1: begin
                next_wr.we   = 1'b1;
                next_wr.addr = allfl_pkg::slot_of(r_slot);
                next_wr.data = r_free_head;
                prev_wr.we   = 1'b1;
                prev_wr.addr = allfl_pkg::slot_of(r_slot);
                prev_wr.data = allfl_pkg::NONE_LINK;
                n_state      = allfl_pkg::ST_DL_U2;
            end

            allfl_pkg::ST_DL_U2: begin
                prev_wr.we   = allfl_pkg::is_slot(r_free_head);
                prev_wr.addr = allfl_pkg::slot_of(r_free_head);
                prev_wr.data = r_slot;
                if (!allfl_pkg::is_slot(r_lp)) begin
                    n_head = allfl_pkg::norm_link(r_ln);
                end
                if (!allfl_pkg::is_slot(r_ln)) begin
                    n_tail = allfl_pkg::norm_link(r_lp);
                end
                n_free_head = r_slot;
                if (r_len != '0) begin
                    n_len = r_len - allfl_pkg::t_link'(1);
                end
                n_state = allfl_pkg::ST_FINISH;
            end

            // compactify: walk list and free list, pick the next pair to swap
            allfl_pkg::ST_CP_CHECK: begin
                if (!allfl_pkg::is_slot(r_li) || !allfl_pkg::is_slot(r_fi) ||
                    r_csteps >= allfl_pkg::CP_STEP_MAX) begin
                    n_state = allfl_pkg::ST_FINISH;
                end else begin
                    rd_en    = 1'b1;
                    n_csteps = r_csteps + allfl_pkg::t_step'(1);
                    if (r_li < r_len) begin
                        rd_addr = allfl_pkg::slot_of(r_li);
                        n_state = allfl_pkg::ST_CP_ADV_L;
                    end else if (r_fi >= r_len) begin
                        rd_addr = allfl_pkg::slot_of(r_fi);
                        n_state = allfl_pkg::ST_CP_ADV_F;
                    end else begin
                        rd_addr = allfl_pkg::slot_of(r_li);
                        n_state = allfl_pkg::ST_CP_RD_F;
                    end
                end
            end

            allfl_pkg::ST_CP_ADV_L: begin
                n_li    = r_next_q;
                n_state = allfl_pkg::ST_CP_CHECK;
            end

            allfl_pkg::ST_CP_ADV_F: begin
                n_fi    = r_next_q;
                n_state = allfl_pkg::ST_CP_CHECK;
            end

            // list slot read back; fetch the free slot
            allfl_pkg::ST_CP_RD_F: begin
                n_ln       = r_next_q;
                n_lp       = r_prev_q;
                n_swap_key = r_key_q;
                rd_en      = 1'b1;
                rd_addr    = allfl_pkg::slot_of(r_fi);
                n_state    = allfl_pkg::ST_CP_CAP_F;
            end

            allfl_pkg::ST_CP_CAP_F: begin
                n_fn    = r_next_q;
                n_fp    = r_prev_q;
                n_state = allfl_pkg::ST_CP_W0;
            end

            // move key; list neighbors point at the free slot
            allfl_pkg::ST_CP_W0: begin
                key_we       = 1'b1;
                next_wr.we   = allfl_pkg::is_slot(r_lp);
                next_wr.addr = allfl_pkg::slot_of(r_lp);
                next_wr.data = r_fi;
                prev_wr.we   = allfl_pkg::is_slot(r_ln);
                prev_wr.addr = allfl_pkg::slot_of(r_ln);
                prev_wr.data = r_fi;
                if (!allfl_pkg::is_slot(r_lp)) begin
                    n_head = r_fi;
                end
                if (!allfl_pkg::is_slot(r_ln)) begin
                    n_tail = r_fi;
                end
                n_state = allfl_pkg::ST_CP_W1;
            end

            // free neighbors point at the list slot
            allfl_pkg::ST_CP_W1: begin
                next_wr.we   = allfl_pkg::is_slot(r_fp);
                next_wr.addr = allfl_pkg::slot_of(r_fp);
                next_wr.data = r_li;
                prev_wr.we   = allfl_pkg::is_slot(r_fn);
                prev_wr.addr = allfl_pkg::slot_of(r_fn);
                prev_wr.data = r_li;
                if (!allfl_pkg::is_slot(r_fp)) begin
                    n_free_head = r_li;
                end
                n_state = allfl_pkg::ST_CP_W2;
            end

            allfl_pkg::ST_CP_W2: begin
                next_wr.we   = 1'b1;
                next_wr.addr = allfl_pkg::slot_of(r_li);
                next_wr.data = allfl_pkg::norm_link(r_fn);
                prev_wr.we   = 1'b1;
                prev_wr.addr = allfl_pkg::slot_of(r_li);
                prev_wr.data = allfl_pkg::norm_link(r_fp);
                n_state      = allfl_pkg::ST_CP_W3;
            end

            allfl_pkg::ST_CP_W3: begin
                next_wr.we   = 1'b1;
                next_wr.addr = allfl_pkg::slot_of(r_fi);
                next_wr.data = allfl_pkg::norm_link(r_ln);
                prev_wr.we   = 1'b1;
                prev_wr.addr = allfl_pkg::slot_of(r_fi);
                prev_wr.data = allfl_pkg::norm_link(r_lp);
                n_li         = r_ln;
                n_fi         = r_fn;
                n_state      = allfl_pkg::ST_CP_CHECK;
            end

            // hand the result word to the output register once it is free
            allfl_pkg::ST_FINISH: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_len    = allfl_pkg::FIELD_BITS'(r_len);
                    n_out_head   = allfl_pkg::FIELD_BITS'(r_head);
                    n_out_tail   = allfl_pkg::FIELD_BITS'(r_tail);
                    n_state      = allfl_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = allfl_pkg::ST_IDLE;
            end
        endcase
    end

    // Checks
    `ALLFL_ASSERT(a_len_bound, r_len <= allfl_pkg::SLOTS_LINK, "list length above store size")
    `ALLFL_ASSERT(a_head_len, o_s_tready |-> (no_head == len_zero), "head and length disagree")
    `ALLFL_ASSERT(a_head_tail, o_s_tready |-> (no_head == no_tail), "head and tail disagree")
    `ALLFL_ASSERT(a_busy_after_accept, s_acc |=> !o_s_tready, "word accepted but sequencer idle")

endmodule
